>>> rtl/ncdf_pkg.sv
// Shared constants, types and tables of the normal CDF approximation unit.
package ncdf_pkg;

   localparam int IN_WIDTH_DEF  = 16;
   localparam int OUT_WIDTH_DEF = 16;

   // fraction bits of every internal value
   localparam int FB = 28;
   localparam logic [28:0] ONE = 29'(1) << FB;
   localparam logic [63:0] HALF_LSB = 64'd1 << (FB - 1);

   localparam int DIV_STEPS = 29;
   localparam int EXP_TERMS = 10;
   localparam int SQUARES   = 6;
   localparam int HORNER_STAGES = 6;

   localparam logic [27:0] K_RSQRT2 =
      28'(((64'd7071067812 << FB) + 64'd5000000000) / 64'd10000000000);
   localparam logic [26:0] K_P =
      27'(((64'd327591100 << FB) + 64'd500000000) / 64'd1000000000);

   localparam logic signed [31:0] K_A1 =
      $signed(32'(((64'd254829592 << FB) + 64'd500000000) / 64'd1000000000));
   localparam logic signed [31:0] K_A2 =
      -$signed(32'(((64'd284496736 << FB) + 64'd500000000) / 64'd1000000000));
   localparam logic signed [31:0] K_A3 =
      $signed(32'(((64'd1421413741 << FB) + 64'd500000000) / 64'd1000000000));
   localparam logic signed [31:0] K_A4 =
      -$signed(32'(((64'd1453152027 << FB) + 64'd500000000) / 64'd1000000000));
   localparam logic signed [31:0] K_A5 =
      $signed(32'(((64'd1061405429 << FB) + 64'd500000000) / 64'd1000000000));

   // Horner coefficients, highest order first
   localparam logic signed [31:0] HORNER_K [0:4] = '{K_A5, K_A4, K_A3, K_A2, K_A1};

   // ceil(2^33 / i): exact quotient of a 29-bit value by i after >> 33
   localparam int RECIP_SHIFT = 33;
   localparam logic [33:0] RECIP [1:10] = '{
      34'(((64'd1 << 33) + 64'd0) / 64'd1),
      34'(((64'd1 << 33) + 64'd1) / 64'd2),
      34'(((64'd1 << 33) + 64'd2) / 64'd3),
      34'(((64'd1 << 33) + 64'd3) / 64'd4),
      34'(((64'd1 << 33) + 64'd4) / 64'd5),
      34'(((64'd1 << 33) + 64'd5) / 64'd6),
      34'(((64'd1 << 33) + 64'd6) / 64'd7),
      34'(((64'd1 << 33) + 64'd7) / 64'd8),
      34'(((64'd1 << 33) + 64'd8) / 64'd9),
      34'(((64'd1 << 33) + 64'd9) / 64'd10)
   };

   // one step of the restoring reciprocal divider
   typedef struct packed {
      logic        neg;
      logic [29:0] den;
      logic [29:0] rem;
      logic [28:0] lo;
      logic [28:0] quo;
   } div_cell_type;

endpackage

>>> rtl/normal_cdf_approx_unit.sv
// Standard normal CDF of a signed fixed-point sample, one result per request.
// Phi(x) is formed by the erfc approximation: z = |x|/sqrt2, t = 1/(1 + p*z),
// Phi = 1 - poly5(t)*t*exp(-z*z)/2 for x >= 0 and its mirror for x < 0.
// One request can enter every cycle unless a result waits with no gap left in
// the pipeline. A request passes the sign, z and denominator stages, then the
// 29-cell reciprocal chain, one quotient bit per cell, with exp(-z*z) computed
// alongside it in 29 stages, followed by six Horner stages and the output
// register. Stalled stages hold; empty stages keep filling, so input is taken
// while a result waits as long as the pipeline holds a gap.
module normal_cdf_approx_unit #(
   parameter int IN_WIDTH  = ncdf_pkg::IN_WIDTH_DEF,
   parameter int OUT_WIDTH = ncdf_pkg::OUT_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [IN_WIDTH-1:0]   req_x_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [OUT_WIDTH-1:0]         rsp_probability
);
   import ncdf_pkg::*;

   localparam int ST_DIV0 = 3;
   localparam int ST_HOR0 = ST_DIV0 + DIV_STEPS;
   localparam int ST_OUT  = ST_HOR0 + HORNER_STAGES;
   localparam int NST     = ST_OUT + 1;

   function automatic logic signed [31:0] smulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] pr;
      logic [35:0] mr;
      ma = a[31] ? 32'(-a) : 32'(a);
      mb = b[31] ? 32'(-b) : 32'(b);
      pr = ma * mb;
      mr = 36'((pr + HALF_LSB) >> FB);
      return (a[31] ^ b[31]) ? -$signed(mr[31:0]) : $signed(mr[31:0]);
   endfunction

   // stage control
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST-1:0] en;

   genvar g;
   generate
      for (g = 0; g < NST; g++) begin : g_en
         assign en[g] = !(&valid_ff[NST-1:g]) || !rsp_stall;
      end
   endgenerate

   assign valid_in = (en & {valid_ff[NST-2:0], req_valid}) | (~en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NST-1];

   // stage 0: sign and magnitude
   logic [IN_WIDTH-1:0] mag;
   logic                neg0_ff;
   logic [31:0]         ax0_ff;

   assign mag = req_x_value[IN_WIDTH-1] ? IN_WIDTH'(-req_x_value) : IN_WIDTH'(req_x_value);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg0_ff <= req_x_value[IN_WIDTH-1];
         ax0_ff  <= 32'(mag) << (32 - IN_WIDTH);
      end
   end

   // stage 1: z = |x| / sqrt2
   logic [59:0] zp;
   logic        neg1_ff;
   logic [30:0] z1_ff;

   assign zp = ax0_ff * K_RSQRT2 + 60'(HALF_LSB);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         neg1_ff <= neg0_ff;
         z1_ff   <= zp[58:28];
      end
   end

   // stage 2: denominator and z squared
   logic [57:0] pzp;
   logic [62:0] wp;
   logic        neg2_ff;
   logic [29:0] den2_ff;
   logic [33:0] w2_ff;

   assign pzp = K_P * z1_ff + 58'(HALF_LSB);
   assign wp  = z1_ff * z1_ff + 63'(HALF_LSB);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         neg2_ff <= neg1_ff;
         den2_ff <= 30'(ONE) + {1'b0, pzp[56:28]};
         w2_ff   <= wp[61:28];
      end
   end

   // reciprocal chain: 2^56 + den/2 divided by den
   div_cell_type cell_src [0:DIV_STEPS-1];
   div_cell_type cell_ff  [0:DIV_STEPS-1];

   generate
      for (g = 0; g < DIV_STEPS; g++) begin : g_div
         if (g == 0) begin : g_head
            always_comb begin
               cell_src[g].neg = neg2_ff;
               cell_src[g].den = den2_ff;
               cell_src[g].rem = 30'(1) << (FB - 1);
               cell_src[g].lo  = den2_ff[29:1];
               cell_src[g].quo = '0;
            end
         end else begin : g_link
            assign cell_src[g] = cell_ff[g-1];
         end
         ncdf_div_cell u_cell (
            .clock   (clock),
            .en      (en[ST_DIV0 + g]),
            .prev    (cell_src[g]),
            .cell_ff (cell_ff[g])
         );
      end
   endgenerate

   logic [28:0] e_value;

   ncdf_exp_lane u_exp (
      .clock    (clock),
      .stage_en (en[ST_HOR0-1:ST_DIV0]),
      .w_value  (w2_ff),
      .e_value  (e_value)
   );

   // t must stay with its request through the Horner stages
   logic [28:0]        t_ff  [0:HORNER_STAGES-3];
   logic signed [31:0] t_src [0:HORNER_STAGES-2];

   assign t_src[0] = $signed({3'b000, cell_ff[DIV_STEPS-1].quo});

   generate
      for (g = 0; g < HORNER_STAGES - 2; g++) begin : g_thold
         always_ff @(posedge clock) begin
            if (en[ST_HOR0 + g]) begin
               t_ff[g] <= t_src[g][28:0];
            end
         end
         assign t_src[g+1] = $signed({3'b000, t_ff[g]});
      end
   endgenerate

   // Horner stages
   logic signed [31:0] poly_ff [0:HORNER_STAGES-1];
   logic signed [31:0] poly_in [0:HORNER_STAGES-1];
   logic signed [31:0] poly_src[0:HORNER_STAGES-1];
   logic [28:0]        e_ff    [0:HORNER_STAGES-1];
   logic [28:0]        e_src   [0:HORNER_STAGES-1];
   logic               neg_ff  [0:HORNER_STAGES-1];
   logic               neg_src [0:HORNER_STAGES-1];

   generate
      for (g = 0; g < HORNER_STAGES; g++) begin : g_hor
         if (g == 0) begin : g_head
            assign poly_src[g] = HORNER_K[0];
            assign e_src[g]    = e_value;
            assign neg_src[g]  = cell_ff[DIV_STEPS-1].neg;
         end else begin : g_link
            assign poly_src[g] = poly_ff[g-1];
            assign e_src[g]    = e_ff[g-1];
            assign neg_src[g]  = neg_ff[g-1];
         end

         if (g < 4) begin : g_coef
            assign poly_in[g] = smulq(poly_src[g], t_src[g]) + HORNER_K[g+1];
         end else if (g == 4) begin : g_times_t
            assign poly_in[g] = smulq(poly_src[g], t_src[g]);
         end else begin : g_times_e
            logic signed [31:0] qs;
            assign qs = smulq(poly_src[g], $signed({3'b000, e_src[g]}));
            // clamp to [0, 1]
            assign poly_in[g] = qs[31] ? '0 :
                                (qs > $signed({3'b000, ONE})) ? $signed({3'b000, ONE}) : qs;
         end

         always_ff @(posedge clock) begin
            if (en[ST_HOR0 + g]) begin
               poly_ff[g] <= poly_in[g];
               e_ff[g]    <= e_src[g];
               neg_ff[g]  <= neg_src[g];
            end
         end
      end
   endgenerate

   // output stage: fold by sign, round to OUT_WIDTH, saturate
   logic [28:0]        q_half;
   logic [28:0]        v;
   logic [OUT_WIDTH:0] r;
   logic [OUT_WIDTH-1:0] rsp_probability_ff;

   assign q_half = {1'b0, poly_ff[HORNER_STAGES-1][28:1]};
   assign v      = neg_ff[HORNER_STAGES-1] ? q_half : ONE - q_half;

   generate
      if (OUT_WIDTH < FB) begin : g_round
         localparam int S = FB - OUT_WIDTH;
         logic [28:0] vr;
         assign vr = v + (29'(1) << (S - 1));
         assign r  = vr[28:S];
      end else if (OUT_WIDTH == FB) begin : g_same
         assign r = v;
      end else begin : g_widen
         assign r = {v, {(OUT_WIDTH - FB){1'b0}}};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         rsp_probability_ff <= r[OUT_WIDTH] ? '1 : r[OUT_WIDTH-1:0];
      end
   end

   assign rsp_probability = rsp_probability_ff;

   // checks
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted request not captured");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("input stalled with a gap in the pipeline");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NST-2] && en[NST-1]) |=> rsp_valid)
      else $error("result lost before output register");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

>>> rtl/ncdf_div_cell.sv
// One restoring division cell: produces one quotient bit per request.
module ncdf_div_cell (
   input  logic                  clock,
   input  logic                  en,
   input  ncdf_pkg::div_cell_type prev,
   output ncdf_pkg::div_cell_type cell_ff
);
   import ncdf_pkg::*;

   logic [30:0]  shifted;
   logic [31:0]  diff;
   logic         ge;
   div_cell_type cell_in;

   always_comb begin
      shifted      = {prev.rem, prev.lo[28]};
      diff         = {1'b0, shifted} - {2'b00, prev.den};
      ge           = !diff[31];
      cell_in.neg  = prev.neg;
      cell_in.den  = prev.den;
      cell_in.rem  = ge ? diff[29:0] : shifted[29:0];
      cell_in.lo   = {prev.lo[27:0], 1'b0};
      cell_in.quo  = {prev.quo[27:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

endmodule

>>> rtl/ncdf_exp_lane.sv
// Pipelined exp(-w): Taylor series in Horner form followed by six squarings and pass-through stages.
module ncdf_exp_lane (
   input  logic                              clock,
   input  logic [ncdf_pkg::DIV_STEPS-1:0]    stage_en,
   input  logic [33:0]                       w_value,
   output logic [28:0]                       e_value
);
   import ncdf_pkg::*;

   localparam int TAYLOR_STAGES = 2 * EXP_TERMS;

   logic [27:0] u_ff   [0:DIV_STEPS-1];
   logic [28:0] acc_ff [0:DIV_STEPS-1];
   logic [27:0] u_src  [0:DIV_STEPS-1];
   logic [28:0] acc_src[0:DIV_STEPS-1];
   logic [28:0] acc_in [0:DIV_STEPS-1];
   logic [34:0] w_round;

   // u = (w + 32) >> 6
   assign w_round = {1'b0, w_value} + 35'd32;

   genvar k;
   generate
      for (k = 0; k < DIV_STEPS; k++) begin : g_stage
         if (k == 0) begin : g_first
            assign u_src[k]   = w_round[33:6];
            assign acc_src[k] = ONE;
         end else begin : g_next
            assign u_src[k]   = u_ff[k-1];
            assign acc_src[k] = acc_ff[k-1];
         end

         if (k < TAYLOR_STAGES && (k % 2) == 0) begin : g_mul
            localparam int TERM = EXP_TERMS - k / 2;
            localparam logic [28:0] RND = 29'(TERM / 2);
            logic [57:0] prod;
            assign prod      = u_src[k] * acc_src[k] + 58'(HALF_LSB);
            assign acc_in[k] = prod[56:28] + RND;
         end else if (k < TAYLOR_STAGES) begin : g_div
            localparam int TERM = EXP_TERMS - k / 2;
            logic [62:0] prod;
            assign prod      = acc_src[k] * RECIP[TERM];
            assign acc_in[k] = ONE - prod[61:RECIP_SHIFT];
         end else if (k < TAYLOR_STAGES + SQUARES) begin : g_square
            logic [58:0] prod;
            assign prod      = acc_src[k] * acc_src[k] + 59'(HALF_LSB);
            assign acc_in[k] = prod[56:28];
         end else begin : g_pass
            assign acc_in[k] = acc_src[k];
         end

         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               u_ff[k]   <= u_src[k];
               acc_ff[k] <= acc_in[k];
            end
         end
      end
   endgenerate

   assign e_value = acc_ff[DIV_STEPS-1];

endmodule
